/* design/bilinear_grid_interpolation_defines.svh */
// Assertion macros for the bilinear grid interpolator.
// Used by the top level only; needs i_clk and i_rst_n in scope.
`ifndef BILINEAR_GRID_INTERPOLATION_DEFINES_SVH
`define BILINEAR_GRID_INTERPOLATION_DEFINES_SVH

// Checked while out of reset.
`define BGI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define BGI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* design/bgi_pkg.sv */
// Package for the bilinear grid interpolator: sizes, register indexes,
// item structs, state enum and the grid size clamp. No dependencies.
package bgi_pkg;

    localparam int MAX_COLS  = 64;
    localparam int MAX_ROWS  = 64;
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam int CNT_W  = 7;
    localparam int NUM_W  = 56;   // |diff * (n-1)| shifted by 16 fraction bits
    localparam int DCNT_W = $clog2(NUM_W);

    localparam logic [2:0] CFG_COLS    = 3'd0;
    localparam logic [2:0] CFG_ROWS    = 3'd1;
    localparam logic [2:0] CFG_X_LOWER = 3'd2;
    localparam logic [2:0] CFG_X_UPPER = 3'd3;
    localparam logic [2:0] CFG_Y_LOWER = 3'd4;
    localparam logic [2:0] CFG_Y_UPPER = 3'd5;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic               action;
        logic [5:0]         cell_row;
        logic [5:0]         cell_col;
        logic signed [31:0] cell_value;
        logic signed [31:0] query_x;
        logic signed [31:0] query_y;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] interpolated_value;
        logic               degenerate_span;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_LOC,
        S_RD00,
        S_RD01,
        S_RD10,
        S_RD11,
        S_RDLAST,
        S_MIX0,
        S_MIX1,
        S_MIX2
    } t_state;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                     input int maxv);
        logic [CNT_W-1:0] res;
        if (v < CNT_W'(2)) begin
            res = CNT_W'(2);
        end else if (32'(v) > maxv) begin
            res = CNT_W'(maxv);
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

/* design/bilinear_grid_interpolation.sv */
// Bilinear grid interpolator top level: grid memory, shared divider,
// blend datapath. Depends on bgi_pkg and bilinear_grid_interpolation_defines.svh.
//
// Usage:
//   Items enter on i_item when start is high and busy is low. A write item
//   (action 0) stores cell_value at (cell_row, cell_col) and yields no result;
//   busy stays low, so writes go back to back.
//   A query item (action 1) yields one result on o_result, marked by
//   o_result_valid for exactly one cycle; a query over a nonzero span raises busy.
//   Query flow: when a span is zero (degenerate), result 0 is strobed in the
//   cycle after accept and busy stays low. Otherwise each axis passes through a setup
//   state, the one-bit-per-cycle restoring divider that maps the coordinate
//   to cell units, and a locate state; the four corners then come one per
//   cycle through the single grid read port, and the blend runs through the
//   registered multiply states MIX0, MIX1 and MIX2 before the strobe.
//   Configuration goes through i_cfg_we / i_cfg_idx / i_cfg_data, one register per cycle;
//   the user must write only while busy is low and no result is pending; the block does not enforce it.
//   Reset restores the register defaults (64x64 grid over 0..63.0); the
//   grid contents are undefined until written.
//   The receiver cannot stall: each result is shown for one cycle only.
module bilinear_grid_interpolation (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  bgi_pkg::t_in_item i_item,
    output logic              busy,
    output logic              o_result_valid,
    output bgi_pkg::t_out_item o_result,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data
);
    import bgi_pkg::*;

    `include "bilinear_grid_interpolation_defines.svh"

    // configuration
    logic [CNT_W-1:0]   r_cols, r_rows;
    logic signed [31:0] r_x_lo, r_x_hi, r_y_lo, r_y_hi;

    t_state r_state, n_state;

    // query
    logic signed [31:0] r_qx, r_qy;
    logic               r_axis;

    // divider
    logic [NUM_W-1:0]   r_num;
    logic [33:0]        r_rem;
    logic [32:0]        r_den;
    logic               r_neg;
    logic [DCNT_W-1:0]  r_cnt;

    // located cell and offsets
    logic [COL_W-1:0]   r_i;
    logic [ROW_W-1:0]   r_j;
    logic signed [22:0] r_tx, r_ty;

    // corners and blend
    logic signed [31:0] r_mem [MEM_DEPTH];
    logic signed [31:0] r_rdata;
    logic signed [31:0] r_c00, r_c01, r_c10, r_c11;
    logic signed [39:0] r_v0, r_v1;
    logic signed [44:0] r_pl;
    logic signed [42:0] r_ph;

    logic               r_out_valid;
    t_out_item          r_out;

    // control decode
    logic               w_accept, w_wr_en, w_degen;
    logic [ADDR_W-1:0]  w_wr_addr, w_rd_addr;

    assign w_accept = start && !busy;
    assign w_degen  = (r_x_hi == r_x_lo) || (r_y_hi == r_y_lo);
    assign w_wr_en  = w_accept && (i_item.action == ACT_WRITE)
                      && (32'(i_item.cell_row) < MAX_ROWS)
                      && (32'(i_item.cell_col) < MAX_COLS);
    assign w_wr_addr = ADDR_W'(i_item.cell_row) * ADDR_W'(MAX_COLS)
                       + ADDR_W'(i_item.cell_col);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_item.action == ACT_QUERY && !w_degen) begin
                    n_state = S_PREP;
                end
            end
            S_PREP:   n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == DCNT_W'(NUM_W - 1)) begin
                    n_state = S_LOC;
                end
            end
            S_LOC:    n_state = r_axis ? S_RD00 : S_PREP;
            S_RD00:   n_state = S_RD01;
            S_RD01:   n_state = S_RD10;
            S_RD10:   n_state = S_RD11;
            S_RD11:   n_state = S_RDLAST;
            S_RDLAST: n_state = S_MIX0;
            S_MIX0:   n_state = S_MIX1;
            S_MIX1:   n_state = S_MIX2;
            S_MIX2:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // ---------------- state outputs ----------------
    logic [ROW_W-1:0] w_rd_row;
    logic [COL_W-1:0] w_rd_col;

    always_comb begin
        busy     = (r_state != S_IDLE);
        w_rd_row = r_j;
        w_rd_col = r_i;
        unique case (r_state)
            S_RD01: w_rd_col = r_i + COL_W'(1);
            S_RD10: w_rd_row = r_j + ROW_W'(1);
            S_RD11: begin
                w_rd_row = r_j + ROW_W'(1);
                w_rd_col = r_i + COL_W'(1);
            end
            default: begin
                w_rd_row = r_j;
                w_rd_col = r_i;
            end
        endcase
        w_rd_addr = ADDR_W'(w_rd_row) * ADDR_W'(MAX_COLS) + ADDR_W'(w_rd_col);
    end

    // ---------------- locate arithmetic ----------------
    logic [CNT_W-1:0]   w_n, w_nm1, w_nm2;
    logic signed [32:0] w_diff, w_span;
    logic signed [40:0] w_nprod;
    logic [39:0]        w_nmag;
    logic [32:0]        w_smag;
    logic [33:0]        w_trial;
    logic               w_qbit;
    logic [39:0]        w_kraw;
    logic [CNT_W-1:0]   w_k;
    logic signed [57:0] w_t;
    logic signed [22:0] w_tsat;
    logic               w_fneg;

    always_comb begin
        w_n    = r_axis ? clamp_count(r_rows, MAX_ROWS) : clamp_count(r_cols, MAX_COLS);
        w_nm1  = w_n - CNT_W'(1);
        w_nm2  = w_n - CNT_W'(2);
        w_diff = r_axis ? (33'(r_qy) - 33'(r_y_lo)) : (33'(r_qx) - 33'(r_x_lo));
        w_span = r_axis ? (33'(r_y_hi) - 33'(r_y_lo)) : (33'(r_x_hi) - 33'(r_x_lo));
        w_nprod = w_diff * $signed({1'b0, w_nm1});
        w_nmag  = w_nprod[40] ? 40'(-w_nprod) : 40'(w_nprod);
        w_smag  = w_span[32] ? 33'(-w_span) : 33'(w_span);

        // one restoring step: shift in the next dividend bit
        w_trial = {r_rem[32:0], r_num[NUM_W-1]};
        w_qbit  = (w_trial >= {1'b0, r_den});

        // truncated quotient: negative values clamp the index to zero
        w_fneg = r_neg && (r_num != '0);
        w_kraw = r_num[NUM_W-1:16];
        if (w_fneg) begin
            w_k = '0;
            w_t = -$signed({2'b00, r_num});
        end else begin
            w_k = (w_kraw > 40'(w_nm2)) ? w_nm2 : w_kraw[CNT_W-1:0];
            w_t = $signed({2'b00, r_num}) - $signed({35'd0, w_k, 16'd0});
        end
        if (w_t > 58'sd4194303) begin
            w_tsat = 23'sd4194303;
        end else if (w_t < -58'sd4194304) begin
            w_tsat = -23'sd4194304;
        end else begin
            w_tsat = w_t[22:0];
        end
    end

    // ---------------- blend arithmetic ----------------
    logic signed [55:0] w_p0, w_p1;
    logic signed [40:0] w_d;
    logic signed [44:0] w_pl;
    logic signed [42:0] w_ph;
    logic signed [63:0] w_prod;
    logic signed [48:0] w_v;
    logic signed [31:0] w_vsat;

    always_comb begin
        w_p0 = (33'(r_c01) - 33'(r_c00)) * r_tx;
        w_p1 = (33'(r_c11) - 33'(r_c10)) * r_tx;
        w_d  = 41'(r_v1) - 41'(r_v0);
        // split the wide difference into two narrow products
        w_pl = $signed({1'b0, w_d[20:0]}) * r_ty;
        w_ph = $signed(w_d[40:21]) * r_ty;
        w_prod = (64'(r_ph) <<< 21) + 64'(r_pl);
        w_v    = 49'(r_v0) + 49'(w_prod >>> 16);
        if (w_v > 49'sd2147483647) begin
            w_vsat = 32'sh7FFFFFFF;
        end else if (w_v < -49'sd2147483648) begin
            w_vsat = 32'sh80000000;
        end else begin
            w_vsat = w_v[31:0];
        end
    end

    // ---------------- grid memory ----------------
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= i_item.cell_value;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cols      <= CNT_W'(64);
            r_rows      <= CNT_W'(64);
            r_x_lo      <= 32'sd0;
            r_x_hi      <= 32'sd4128768;
            r_y_lo      <= 32'sd0;
            r_y_hi      <= 32'sd4128768;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (w_accept && i_item.action == ACT_QUERY && w_degen)
                           || (r_state == S_MIX2);
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_COLS:    r_cols <= i_cfg_data[CNT_W-1:0];
                    CFG_ROWS:    r_rows <= i_cfg_data[CNT_W-1:0];
                    CFG_X_LOWER: r_x_lo <= i_cfg_data;
                    CFG_X_UPPER: r_x_hi <= i_cfg_data;
                    CFG_Y_LOWER: r_y_lo <= i_cfg_data;
                    CFG_Y_UPPER: r_y_hi <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_qx   <= i_item.query_x;
                r_qy   <= i_item.query_y;
                r_axis <= 1'b0;
                r_out  <= '{interpolated_value: 32'sd0, degenerate_span: 1'b1};
            end
            S_PREP: begin
                r_num <= {w_nmag, 16'd0};
                r_den <= w_smag;
                r_rem <= '0;
                r_neg <= w_nprod[40] ^ w_span[32];
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= w_qbit ? (w_trial - {1'b0, r_den}) : w_trial;
                r_num <= {r_num[NUM_W-2:0], w_qbit};
                r_cnt <= r_cnt + DCNT_W'(1);
            end
            S_LOC: begin
                if (r_axis) begin
                    r_j  <= ROW_W'(w_k);
                    r_ty <= w_tsat;
                end else begin
                    r_i  <= COL_W'(w_k);
                    r_tx <= w_tsat;
                end
                r_axis <= 1'b1;
            end
            S_RD01:   r_c00 <= r_rdata;
            S_RD10:   r_c01 <= r_rdata;
            S_RD11:   r_c10 <= r_rdata;
            S_RDLAST: r_c11 <= r_rdata;
            S_MIX0: begin
                r_v0 <= 40'(r_c00) + 40'(w_p0 >>> 16);
                r_v1 <= 40'(r_c10) + 40'(w_p1 >>> 16);
            end
            S_MIX1: begin
                r_pl <= w_pl;
                r_ph <= w_ph;
            end
            S_MIX2: begin
                r_out <= '{interpolated_value: w_vsat, degenerate_span: 1'b0};
            end
            default: ;
        endcase
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    // ---------------- assertions ----------------
    `BGI_ASSERT(a_degen_zero, o_result_valid && o_result.degenerate_span |-> o_result.interpolated_value == 32'sd0, "degenerate result not zero")
    `BGI_ASSERT(a_write_silent, start && !busy && i_item.action == ACT_WRITE |=> !o_result_valid, "write item produced a result")
    `BGI_ASSERT(a_idx_range, r_state == S_RD00 |-> (32'(r_i) <= MAX_COLS - 2) && (32'(r_j) <= MAX_ROWS - 2), "cell index past last interior cell")
    `BGI_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_result_valid && !busy, "activity right after reset")

endmodule
